### rtl/core/tdmc_pkg.sv
// Shared types and constants of the thermostat, display and motor controller.
package tdmc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int DUTY_MAX    = 100;
   localparam int SPEED_W     = 7;
   localparam int TEMP_W      = 8;
   localparam int SAMPLE_W    = 16;
   localparam int FRAME_W     = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;

   localparam logic [TEMP_W-1:0]  SETPOINT_RESET = TEMP_W'(200);
   localparam logic [TEMP_W-1:0]  SETPOINT_MAX   = TEMP_W'(255);
   localparam logic [SPEED_W-1:0] SPEED_RESET    = SPEED_W'(100);
   localparam logic [SPEED_W-1:0] SPEED_STEP     = SPEED_W'(10);

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_BUTTON   = 2'd1,
      CMD_SAMPLE   = 2'd2,
      CMD_TABLE_WR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      POS_HUNDREDS = 2'd0,
      POS_TENS     = 2'd1,
      POS_ONES     = 2'd2,
      POS_UNUSED   = 2'd3
   } digit_pos_type;

   // What the display encoder needs to build one shift frame.
   typedef struct packed {
      logic [TEMP_W-1:0] value;
      digit_pos_type     pos;
      logic              dp;
      logic              heater;
      logic              motor;
   } disp_req_type;

endpackage

### rtl/core/tdmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tdmc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tdmc_interp.sv
// Linear interpolation between two neighbouring calibration entries.
module tdmc_interp
   import tdmc_pkg::*;
(
   input  logic [TEMP_W-1:0]   entry_lo,
   input  logic [TEMP_W-1:0]   entry_hi,
   input  logic [SAMPLE_W-1:0] sample,
   output logic [TEMP_W-1:0]   temp
);

   logic [TEMP_W-1:0]          idx;
   logic [TEMP_W-1:0]          frac;
   logic signed [TEMP_W:0]     diff;
   logic signed [2*TEMP_W+1:0] prod;
   logic signed [2*TEMP_W+1:0] step;
   logic signed [2*TEMP_W+1:0] res;

   assign idx  = sample[SAMPLE_W-1:TEMP_W];
   assign frac = sample[TEMP_W-1:0];

   // Signed difference times the fraction; the arithmetic shift floors.
   assign diff = $signed({1'b0, entry_lo}) - $signed({1'b0, entry_hi});
   assign prod = $signed({{(TEMP_W+2){1'b0}}, frac}) *
                 $signed({{(TEMP_W+1){diff[TEMP_W]}}, diff});
   assign step = prod >>> TEMP_W;
   assign res  = $signed({{(TEMP_W+2){1'b0}}, entry_lo}) - step;

   // With index zero the upper read already holds entry zero.
   assign temp = (idx == '0) ? entry_hi : res[TEMP_W-1:0];

endmodule

### rtl/core/tdmc_display.sv
// Seven-segment frame encoder for one digit of the three-digit display.
module tdmc_display
   import tdmc_pkg::*;
(
   input  disp_req_type       disp,
   output logic [FRAME_W-1:0] frame
);

   localparam logic [7:0] SEG_A  = 8'h80;
   localparam logic [7:0] SEG_B  = 8'h20;
   localparam logic [7:0] SEG_C  = 8'h08;
   localparam logic [7:0] SEG_D  = 8'h02;
   localparam logic [7:0] SEG_E  = 8'h01;
   localparam logic [7:0] SEG_F  = 8'h40;
   localparam logic [7:0] SEG_G  = 8'h10;
   localparam logic [7:0] SEG_DP = 8'h04;

   localparam logic [7:0] SEG_DIGITS [10] = '{
      SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F,
      SEG_B | SEG_C,
      SEG_A | SEG_B | SEG_D | SEG_E | SEG_G,
      SEG_A | SEG_B | SEG_C | SEG_D | SEG_G,
      SEG_B | SEG_C | SEG_F | SEG_G,
      SEG_A | SEG_C | SEG_D | SEG_F | SEG_G,
      SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G,
      SEG_A | SEG_B | SEG_C,
      SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G,
      SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G
   };

   logic [1:0]  hundreds;
   logic [6:0]  rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [3:0]  digit;
   logic [2:0]  select;
   logic [7:0]  seg;

   // The value is at most 255, so the hundreds digit comes from two compares
   // and the tens from a multiply by the reciprocal of ten.
   always_comb begin
      if (disp.value >= 8'd200) begin
         hundreds = 2'd2;
      end else if (disp.value >= 8'd100) begin
         hundreds = 2'd1;
      end else begin
         hundreds = 2'd0;
      end
   end

   assign rem       = 7'(disp.value - 8'(hundreds) * 8'd100);
   assign tens_prod = 15'(rem) * 15'd205;
   assign tens      = tens_prod[14:11];
   assign ones      = 4'(rem - 7'(tens) * 7'd10);

   always_comb begin
      unique case (disp.pos)
         POS_TENS: begin
            digit  = tens;
            select = 3'b010;
         end
         POS_ONES: begin
            digit  = ones;
            select = 3'b100;
         end
         POS_HUNDREDS: begin
            digit  = {2'b00, hundreds};
            select = 3'b001;
         end
         default: begin
            digit  = {2'b00, hundreds};
            select = 3'b000;
         end
      endcase
   end

   assign seg   = SEG_DIGITS[digit] | (disp.dp ? SEG_DP : 8'h00);
   assign frame = {1'b0, disp.motor, disp.heater, select, 2'b00, seg};

endmodule

### rtl/core/thermostat_display_motor_controller.sv
// Top level of the thermostat, display and motor controller.
//
// Requests arrive as beats on the req_ stream; req_tuser carries the command
// (tick, button event, converter sample or calibration table write) and
// req_tdata the operands. Every request beat gives exactly one response beat
// on the rsp_ stream, in order. rsp_tuser is the frame flag, set only on
// ticks, and rsp_tdata holds the frame together with the current heater,
// motor, temperature, setpoint and speed after the request took effect.
// The calibration table sits in two copies of a 256 by 8 synchronous RAM so
// that entries i-1 and i are read together in the cycle of acceptance; table
// writes go to both copies at acceptance, so a sample that follows a write
// sees it. The RAM read data is registered at the accepting edge, and the
// interpolation and state update load the response register as the request
// leaves the update stage. A new beat is accepted every cycle while the
// receiver takes the responses. If the receiver stalls, the response
// waits in its register, one more request is held in the update stage, and
// req_tready then falls until the response is taken. Reset clears both
// stages and restores setpoint 200, speed 100 and all other state to zero;
// the table contents are undefined until written.
module thermostat_display_motor_controller
   import tdmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // modifier_held[0], up_pressed[1], down_pressed[2], adc_sample[18:3],
   // table_index[26:19], table_value[34:27], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame[15:0], heater_on[16], motor_reverse[17], temperature_now[25:18],
   // setpoint_now[33:26], speed_now[40:34], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // frame_valid[0]
   output logic                  rsp_tuser
);

   // Fields of the incoming beat.
   logic                  req_accept;
   logic                  in_modifier;
   logic                  in_up;
   logic                  in_down;
   logic [SAMPLE_W-1:0]   in_sample;
   logic [TABLE_AW-1:0]   in_tidx;
   logic [TEMP_W-1:0]     in_tval;
   cmd_type               in_cmd;
   logic [TABLE_AW-1:0]   idx_lo;

   assign req_accept  = req_tvalid && req_tready;
   assign in_modifier = req_tdata[0];
   assign in_up       = req_tdata[1];
   assign in_down     = req_tdata[2];
   assign in_sample   = req_tdata[18:3];
   assign in_tidx     = req_tdata[26:19];
   assign in_tval     = req_tdata[34:27];
   assign in_cmd      = cmd_type'(req_tuser);
   assign idx_lo      = in_sample[SAMPLE_W-1:TEMP_W] - TABLE_AW'(1);

   // Update stage: the request held while its table entries are read.
   logic                  s1_valid_ff, s1_valid_in;
   cmd_type               s1_cmd_ff;
   logic                  s1_modifier_ff;
   logic                  s1_up_ff;
   logic                  s1_down_ff;
   logic [SAMPLE_W-1:0]   s1_sample_ff;
   logic                  s1_advance;

   // Architectural state.
   logic [TEMP_W-1:0]     setpoint_ff, setpoint_in;
   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [TEMP_W-1:0]     temp_ff, temp_in;
   logic                  show_sp_ff, show_sp_in;
   digit_pos_type         pos_ff, pos_in;
   logic [SPEED_W-1:0]    duty_ff, duty_in;
   logic                  heater_ff, heater_in;
   logic                  motor_ff, motor_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic                  rsp_fvalid_ff, rsp_fvalid_in;

   logic [TEMP_W-1:0]     entry_lo;
   logic [TEMP_W-1:0]     entry_hi;
   logic [TEMP_W-1:0]     interp_temp;
   disp_req_type          disp;
   logic [FRAME_W-1:0]    disp_frame;
   logic [SPEED_W:0]      speed_up_sum;

   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   // Both copies take every write; the lower copy serves entry i-1.
   tdmc_ram #(.Width(TEMP_W), .Depth(TABLE_DEPTH)) u_table_lo (
      .clock   (clock),
      .wr_en   (req_accept && (in_cmd == CMD_TABLE_WR)),
      .wr_addr (in_tidx),
      .wr_data (in_tval),
      .rd_en   (req_accept),
      .rd_addr (idx_lo),
      .rd_data (entry_lo)
   );

   tdmc_ram #(.Width(TEMP_W), .Depth(TABLE_DEPTH)) u_table_hi (
      .clock   (clock),
      .wr_en   (req_accept && (in_cmd == CMD_TABLE_WR)),
      .wr_addr (in_tidx),
      .wr_data (in_tval),
      .rd_en   (req_accept),
      .rd_addr (in_sample[SAMPLE_W-1:TEMP_W]),
      .rd_data (entry_hi)
   );

   tdmc_interp u_interp (
      .entry_lo (entry_lo),
      .entry_hi (entry_hi),
      .sample   (s1_sample_ff),
      .temp     (interp_temp)
   );

   // The shown value and the decimal point follow the modifier at tick time.
   always_comb begin
      disp.pos    = pos_ff;
      disp.heater = heater_ff;
      disp.motor  = motor_ff;
      if (s1_modifier_ff) begin
         disp.value = TEMP_W'(speed_ff);
         disp.dp    = 1'b0;
      end else begin
         disp.value = show_sp_ff ? setpoint_ff : temp_ff;
         disp.dp    = show_sp_ff;
      end
   end

   tdmc_display u_display (
      .disp  (disp),
      .frame (disp_frame)
   );

   assign speed_up_sum = {1'b0, speed_ff} + {1'b0, SPEED_STEP};

   // State update for the request leaving the update stage.
   always_comb begin
      setpoint_in   = setpoint_ff;
      speed_in      = speed_ff;
      temp_in       = temp_ff;
      show_sp_in    = show_sp_ff;
      pos_in        = pos_ff;
      duty_in       = duty_ff;
      heater_in     = heater_ff;
      motor_in      = motor_ff;
      rsp_frame_in  = '0;
      rsp_fvalid_in = 1'b0;
      if (s1_advance) begin
         unique case (s1_cmd_ff)
            CMD_TICK: begin
               rsp_frame_in  = disp_frame;
               rsp_fvalid_in = 1'b1;
               if (s1_modifier_ff) begin
                  show_sp_in = 1'b0;
               end
               pos_in  = (pos_ff == POS_HUNDREDS) ? POS_TENS :
                         (pos_ff == POS_TENS) ? POS_ONES : POS_HUNDREDS;
               duty_in = (duty_ff == SPEED_W'(DUTY_MAX)) ? '0 : duty_ff + SPEED_W'(1);
               motor_in = (duty_in > speed_ff);
            end
            CMD_BUTTON: begin
               if (s1_up_ff != s1_down_ff) begin
                  if (s1_modifier_ff) begin
                     if (s1_up_ff) begin
                        if (speed_up_sum <= (SPEED_W+1)'(DUTY_MAX)) begin
                           speed_in = speed_up_sum[SPEED_W-1:0];
                        end
                     end else begin
                        speed_in = (speed_ff >= SPEED_STEP) ? speed_ff - SPEED_STEP : '0;
                     end
                  end else begin
                     if (s1_up_ff) begin
                        if (setpoint_ff != SETPOINT_MAX) begin
                           setpoint_in = setpoint_ff + TEMP_W'(1);
                        end
                     end else if (setpoint_ff != '0) begin
                        setpoint_in = setpoint_ff - TEMP_W'(1);
                     end
                  end
               end
            end
            CMD_SAMPLE: begin
               temp_in    = interp_temp;
               show_sp_in = !show_sp_ff;
               heater_in  = (interp_temp < setpoint_ff);
            end
            CMD_TABLE_WR: begin
               // The table itself was written when the beat was accepted.
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         setpoint_ff  <= SETPOINT_RESET;
         speed_ff     <= SPEED_RESET;
         temp_ff      <= '0;
         show_sp_ff   <= 1'b0;
         pos_ff       <= POS_HUNDREDS;
         duty_ff      <= '0;
         heater_ff    <= 1'b0;
         motor_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         setpoint_ff  <= setpoint_in;
         speed_ff     <= speed_in;
         temp_ff      <= temp_in;
         show_sp_ff   <= show_sp_in;
         pos_ff       <= pos_in;
         duty_ff      <= duty_in;
         heater_ff    <= heater_in;
         motor_ff     <= motor_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff      <= in_cmd;
         s1_modifier_ff <= in_modifier;
         s1_up_ff       <= in_up;
         s1_down_ff     <= in_down;
         s1_sample_ff   <= in_sample;
      end
      if (s1_advance) begin
         rsp_frame_ff  <= rsp_frame_in;
         rsp_fvalid_ff <= rsp_fvalid_in;
      end
   end

   // The state registers already hold the values after the response's request
   // until the next request leaves the update stage, which only happens as
   // the response register is refilled.
   logic [TEMP_W-1:0]  rsp_temp_ff;
   logic [TEMP_W-1:0]  rsp_setpoint_ff;
   logic [SPEED_W-1:0] rsp_speed_ff;
   logic               rsp_heater_ff;
   logic               rsp_motor_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_temp_ff     <= temp_in;
         rsp_setpoint_ff <= setpoint_in;
         rsp_speed_ff    <= speed_in;
         rsp_heater_ff   <= heater_in;
         rsp_motor_ff    <= motor_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_fvalid_ff;
   assign rsp_tdata  = {
      (RSP_DATA_W - FRAME_W - 2 - 2*TEMP_W - SPEED_W)'(0),
      rsp_speed_ff,
      rsp_setpoint_ff,
      rsp_temp_ff,
      rsp_motor_ff,
      rsp_heater_ff,
      rsp_frame_ff
   };

endmodule
